>>> sv/kmhr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmhr_pkg
// Shared types and constants for the key mask to boot keyboard report block.
// ----------------------------------------------------------------------------
package kmhr_pkg;

  localparam int NumKeys   = 32;
  localparam int SlotCount = 6;
  localparam int KeyIdxW   = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int CountW    = $clog2(SlotCount + 1);

  typedef enum logic {
    ActScan  = 1'b0,
    ActWrite = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [31:0] mx_mask;
    logic [31:0] adc_mask;
    logic        host_ready;
    logic [4:0]  map_index;
    logic        map_enabled;
    logic [7:0]  map_keycode;
    logic [7:0]  map_modifiers;
  } in_item_t;

  typedef struct packed {
    logic [7:0] report_modifier;
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [7:0] slot3;
    logic [7:0] slot4;
    logic [7:0] slot5;
  } out_item_t;

  typedef struct packed {
    logic       enabled;
    logic [7:0] keycode;
    logic [7:0] modifiers;
  } entry_t;

endpackage
`default_nettype wire

>>> sv/kmhr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmhr_in_if / kmhr_out_if
// Valid/ready channels carrying input items and report items.
// ----------------------------------------------------------------------------
interface kmhr_in_if;
  logic               valid;
  logic               ready;
  kmhr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kmhr_out_if;
  logic                valid;
  logic                ready;
  kmhr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/key_mask_to_hid_report.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_mask_to_hid_report
// Builds a six-key boot keyboard report from pressed-key masks and a key map.
//
//   Channel | Direction | Transaction
//   in_i    | sink      | map entry write or key scan
//   out_o   | source    | report: modifier byte and six keycodes
//
// A map write or a scan with the host not ready leaves the block idle and ready.
// A scan walks one key map entry per cycle through the map memory read port
// and then compares against the last report.
// The report sits in an output register; a new scan may start while it waits.
// A changed report holds the compare step until the previous report has left.
// Reset clears the key map valid bits and the last sent report.
// ----------------------------------------------------------------------------
module key_mask_to_hid_report (
  input  wire         clk_i,
  input  wire         rst_ni,
  kmhr_in_if.sink     in_i,
  kmhr_out_if.source  out_o
);
  import kmhr_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StDrain = 4'b0100,
    StCmp   = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [KeyIdxW-1:0]   key_q, key_d;
  logic [NumKeys-1:0]   pressed_q, pressed_d;
  logic [NumKeys-1:0]   kv_q;
  entry_t               mem [NumKeys];
  entry_t               rd_data_q;
  logic                 rd_kv_q;
  logic                 rd_vld_q;
  logic                 hit_q;
  logic [CountW-1:0]    count_q;
  logic [7:0]           mod_q;
  logic [7:0]           slots_q [SlotCount];
  logic [7:0]           sent_mod_q;
  logic [7:0]           sent_slots_q [SlotCount];
  logic                 out_vld_q;
  out_item_t            out_q;

  logic                 in_acc;
  logic                 do_write;
  logic                 start_scan;
  logic                 take;
  logic                 changed;
  logic                 load_out;
  logic [31:0]          pressed_all;

  assign in_acc      = in_i.valid && in_i.ready;
  assign do_write    = in_acc && (in_i.data.action == ActWrite) &&
                       ({1'b0, in_i.data.map_index} < 6'(NumKeys));
  assign start_scan  = in_acc && (in_i.data.action == ActScan) && in_i.data.host_ready;
  assign pressed_all = in_i.data.mx_mask | in_i.data.adc_mask;

  assign take = rd_vld_q && hit_q && rd_kv_q && rd_data_q.enabled &&
                (rd_data_q.keycode != 8'd0) && (count_q < CountW'(SlotCount));

  always_comb begin
    changed = (mod_q != sent_mod_q);
    for (int s = 0; s < SlotCount; s++) begin
      if (slots_q[s] != sent_slots_q[s]) begin
        changed = 1'b1;
      end
    end
  end

  assign load_out = (state_q == StCmp) && changed && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    pressed_d = pressed_q;
    case (state_q)
      StIdle: begin
        if (start_scan) begin
          state_d   = StScan;
          key_d     = '0;
          pressed_d = pressed_all[NumKeys-1:0];
        end
      end
      StScan: begin
        pressed_d = pressed_q >> 1;
        key_d     = key_q + 1'b1;
        if (key_q == KeyIdxW'(NumKeys - 1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (!changed || load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_i.ready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      key_q     <= '0;
      pressed_q <= '0;
      kv_q      <= '0;
      rd_vld_q  <= 1'b0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      sent_mod_q <= '0;
      for (int s = 0; s < SlotCount; s++) begin
        sent_slots_q[s] <= '0;
      end
    end else begin
      state_q   <= state_d;
      key_q     <= key_d;
      pressed_q <= pressed_d;
      rd_vld_q  <= (state_q == StScan);
      if (do_write) begin
        kv_q[in_i.data.map_index[KeyIdxW-1:0]] <= 1'b1;
      end
      if (start_scan) begin
        count_q <= '0;
      end else if (take) begin
        count_q <= count_q + 1'b1;
      end
      if (load_out) begin
        out_vld_q  <= 1'b1;
        sent_mod_q <= mod_q;
        for (int s = 0; s < SlotCount; s++) begin
          sent_slots_q[s] <= slots_q[s];
        end
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[in_i.data.map_index[KeyIdxW-1:0]] <= '{enabled:   in_i.data.map_enabled,
                                                 keycode:   in_i.data.map_keycode,
                                                 modifiers: in_i.data.map_modifiers};
    end
    rd_data_q <= mem[key_q];
  end

  always_ff @(posedge clk_i) begin
    rd_kv_q <= kv_q[key_q];
    hit_q   <= pressed_q[0];
    if (start_scan) begin
      mod_q <= '0;
      for (int s = 0; s < SlotCount; s++) begin
        slots_q[s] <= '0;
      end
    end else if (take) begin
      mod_q <= mod_q | rd_data_q.modifiers;
      slots_q[count_q[CountW-1:0]] <= rd_data_q.keycode;
    end
    if (load_out) begin
      out_q.report_modifier <= mod_q;
      out_q.slot0           <= slots_q[0];
      out_q.slot1           <= slots_q[1];
      out_q.slot2           <= slots_q[2];
      out_q.slot3           <= slots_q[3];
      out_q.slot4           <= slots_q[4];
      out_q.slot5           <= slots_q[5];
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire

>>> sv/kmhr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmhr_checker
// Port-level checks on the report block, attached to the report block by bind.
// ----------------------------------------------------------------------------
module kmhr_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_i,
  input wire                  in_action_i,
  input wire                  in_host_ready_i,
  input wire                  out_valid_i,
  input wire                  out_ready_i,
  input kmhr_pkg::out_item_t  out_data_i
);
  import kmhr_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled report keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("report changed while stalled");

  // A map write leaves the block ready in the next cycle.
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ActWrite) |=> in_ready_i)
    else $error("not ready after a map write");

  // A scan with the host ready occupies the block.
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ActScan) && in_host_ready_i |=> !in_ready_i)
    else $error("ready during a scan");

  // A scan with the host not ready produces nothing and stays ready.
  a_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ActScan) && !in_host_ready_i |=>
      in_ready_i && !$rose(out_valid_i))
    else $error("activity after a scan with the host not ready");

endmodule

bind key_mask_to_hid_report kmhr_checker u_kmhr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_action_i     (in_i.data.action),
  .in_host_ready_i (in_i.data.host_ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_data_i      (out_o.data)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks key_mask_to_hid_report against its own model of the keyboard report.
// The driver feeds map writes and scans from a queue and updates the model
// on each accepted transaction. The monitor compares every report,
// field by field, with the oldest expected report. The run has four random
// phases with different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
  import kmhr_pkg::*;

  localparam int ReportW = $bits(out_item_t);
  localparam int FieldCount = ReportW / 8;

  logic clk_i;
  logic rst_ni;

  kmhr_in_if  in_ch ();
  kmhr_out_if out_ch ();

  key_mask_to_hid_report i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  string field_names [FieldCount] = '{"report_modifier", "slot0", "slot1", "slot2",
                                      "slot3", "slot4", "slot5"};

  entry_t    key_table [NumKeys];
  out_item_t last_report;
  out_item_t report_q [$];
  in_item_t  pending_items [$];
  in_item_t  last_scan;
  int        error_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    foreach (key_table[k]) key_table[k] = '0;
    last_report = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic apply_item(input in_item_t it);
    out_item_t   rep;
    logic [7:0]  codes [SlotCount];
    logic [7:0]  mods;
    logic [31:0] pressed;
    int          n;
    if (it.action == ActWrite) begin
      if (it.map_index < NumKeys) begin
        key_table[it.map_index] = {it.map_enabled, it.map_keycode, it.map_modifiers};
      end
    end else if (it.host_ready) begin
      pressed = it.mx_mask | it.adc_mask;
      mods = '0;
      n = 0;
      foreach (codes[s]) codes[s] = '0;
      for (int k = 0; k < NumKeys && n < SlotCount; k++) begin
        if (pressed[k] && key_table[k].enabled && key_table[k].keycode != 8'h00) begin
          mods |= key_table[k].modifiers;
          codes[n] = key_table[k].keycode;
          n++;
        end
      end
      rep = {mods, codes[0], codes[1], codes[2], codes[3], codes[4], codes[5]};
      if (rep != last_report) begin
        last_report = rep;
        report_q.push_back(rep);
      end
    end
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (report_q.size() == 0) begin
      $error("report %h arrived with none expected", got);
      error_count++;
      return;
    end
    want = report_q.pop_front();
    for (int f = 0; f < FieldCount; f++) begin
      if (got[ReportW-1-8*f -: 8] !== want[ReportW-1-8*f -: 8]) begin
        $error("%s: expected %0h, got %0h", field_names[f],
               want[ReportW-1-8*f -: 8], got[ReportW-1-8*f -: 8]);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin : driver
    logic drive;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      drive = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        apply_item(in_ch.data);
        drive = 1'b0;
      end
      if (!drive && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.data <= pending_items.pop_front();
        drive = 1'b1;
      end
      in_ch.valid <= drive;
    end
  end

  always @(posedge clk_i) begin : monitor
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_report(out_ch.data);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t noise_item();
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    return noise[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t write_item(input int idx, input logic en,
                                          input logic [7:0] code, input logic [7:0] mods);
    in_item_t it;
    it = noise_item();
    it.action = ActWrite;
    it.map_index = 5'(idx);
    it.map_enabled = en;
    it.map_keycode = code;
    it.map_modifiers = mods;
    return it;
  endfunction

  function automatic in_item_t scan_item(input logic [31:0] mx, input logic [31:0] adc,
                                         input logic rdy);
    in_item_t it;
    it = noise_item();
    it.action = ActScan;
    it.mx_mask = mx;
    it.adc_mask = adc;
    it.host_ready = rdy;
    return it;
  endfunction

  function automatic logic [31:0] random_mask();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom() & $urandom() & $urandom();
      3: return 32'd1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic fill_random(input int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          it = write_item($urandom_range(NumKeys - 1), $urandom_range(9) != 0,
                          ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom()), 8'($urandom()));
        end
        5, 6, 7: begin
          it = noise_item();
          it.action = ActScan;
          it.mx_mask = last_scan.mx_mask;
          it.adc_mask = last_scan.adc_mask;
          it.host_ready = 1'b1;
        end
        default: begin
          it = scan_item(random_mask(), random_mask(), $urandom_range(6) != 0);
          last_scan = it;
        end
      endcase
      pending_items.push_back(it);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_ch.valid || report_q.size() != 0);
  endtask

  initial begin
    int send_pct [4];
    int stall_pct [4];
    send_pct = '{0, 69, 0, 27};
    stall_pct = '{0, 0, 69, 27};
    last_scan = scan_item('0, '0, 1'b1);
    @(posedge rst_ni);
    @(negedge clk_i);

    pending_items.push_back(scan_item('0, '0, 1'b1));
    pending_items.push_back(write_item(0, 1'b1, 8'h04, 8'h01));
    pending_items.push_back(write_item(31, 1'b1, 8'hFF, 8'h80));
    pending_items.push_back(write_item(5, 1'b0, 8'h10, 8'h02));
    pending_items.push_back(write_item(6, 1'b1, 8'h00, 8'h04));
    pending_items.push_back(scan_item(32'h0000_0001, '0, 1'b1));
    pending_items.push_back(scan_item('0, 32'h0000_0001, 1'b1));
    pending_items.push_back(scan_item(32'h8000_0000, '0, 1'b0));
    pending_items.push_back(scan_item('0, 32'h8000_0001, 1'b1));
    pending_items.push_back(scan_item(32'h0000_0060, '0, 1'b1));
    for (int k = 1; k <= 4; k++) begin
      pending_items.push_back(write_item(k, 1'b1, 8'(8'h04 + k), 8'd1 << k));
    end
    pending_items.push_back(write_item(7, 1'b1, 8'h20, 8'h40));
    pending_items.push_back(write_item(8, 1'b1, 8'h21, 8'h20));
    pending_items.push_back(scan_item('1, '1, 1'b1));
    pending_items.push_back(write_item(0, 1'b1, 8'hFF, 8'hFF));
    pending_items.push_back(scan_item('1, '0, 1'b1));
    pending_items.push_back(write_item(31, 1'b1, 8'h01, 8'h00));
    pending_items.push_back(scan_item(32'h8000_0000, 32'h8000_0000, 1'b1));
    pending_items.push_back(scan_item('0, '0, 1'b1));

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = stall_pct[p];
      fill_random(250);
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (report_q.size() != 0) begin
      $error("%0d expected reports never arrived", report_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/kmhr_pkg.sv
sv/kmhr_if.sv
sv/key_mask_to_hid_report.sv
sv/kmhr_checker.sv
tb/sv/testbench.sv
